@@ sv/ostc_pkg.sv @@
package ostc_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_ADD      = 2'd1,
    REQ_SUBTRACT = 2'd2,
    REQ_FIND     = 2'd3
  } ostc_req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BELOW_MIN = 2'd2,
    ST_OUT_RANGE = 2'd3
  } ostc_status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_FIND_RD,
    S_FIND_STEP,
    S_SUB_T,
    S_ZERO,
    S_FIX_RDL,
    S_FIX_RDR,
    S_FIX_WR,
    S_RESP
  } ostc_state_t;

  localparam int LEVEL_BITS = 12;
  localparam int VALUE_BITS = 13;
  localparam int TOTAL_BITS = 16;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

endpackage

@@ sv/order_statistic_counting_tree.sv @@
// Order-statistic counting tree. Stores a multiset of values as a binary tree of counters
// (2^(KEY_BITS+1) words in one single-port-read RAM) plus a global offset, and serves four
// requests on in_tuser: insert, add to all, subtract from all (dropping entries that fall
// below min_level) and find k-th largest. One request is worked at a time by a sequencer
// around the RAM. Insert does one read-modify-write per level, leaf to root; find one read
// per level, root to leaf; add only moves the offset; subtract runs a zeroing sweep over the
// key slots lying below the new threshold, then rebuilds the counts on the path from the
// threshold up to the root. After reset the RAM is cleared before the first request is taken.
// Every request gives one result; in_tready drops while a request is in progress.
module order_statistic_counting_tree #(
  parameter int KEY_BITS   = 13,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,   // min_level
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // amount [11:0]
  input  logic [1:0]  in_tuser,      // req_type [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,     // found_value [12:0], entry_count [28:13],
                                     // departed_total [44:29]
  output logic [1:0]  out_tuser      // status [1:0]
);

  localparam int NB = KEY_BITS + 1;
  localparam int SW = KEY_BITS + 16;
  localparam logic [NB-1:0] LEAVES = NB'(1) << KEY_BITS;
  localparam logic [NB-1:0] ROOT = NB'(1);
  localparam logic signed [SW-1:0] HALF_S = SW'(1) << (KEY_BITS - 1);
  localparam logic signed [SW-1:0] LEAVES_S = SW'(1) << KEY_BITS;
  localparam logic signed [SW-1:0] VMAX_S = SW'(ostc_pkg::VALUE_MAX);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  ostc_pkg::ostc_state_t state_r, state_nxt;

  logic [11:0]                  min_level_r;
  logic signed [KEY_BITS-1:0]   offset_r, offset_nxt;
  logic [15:0]                  departed_r, departed_nxt;
  logic [COUNT_BITS-1:0]        total_r, total_nxt;
  logic [COUNT_BITS-1:0]        k_r, k_nxt;
  logic [COUNT_BITS-1:0]        left_r, left_nxt;
  logic [NB-1:0]                node_r, node_nxt;
  logic [NB-1:0]                t_r, t_nxt;
  logic [NB-1:0]                zbase_r, zbase_nxt;
  logic [NB-1:0]                zcnt_r, zcnt_nxt;
  logic [NB-1:0]                j_r, j_nxt;
  logic [NB-1:0]                clr_r, clr_nxt;
  logic [1:0]                   status_r, status_nxt;
  logic [12:0]                  found_r, found_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [47:0]                  out_data_r, out_data_nxt;
  logic [1:0]                   out_user_r, out_user_nxt;

  logic                  mem_we, mem_re;
  logic [NB-1:0]         mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;

  logic                  in_acc;
  logic [11:0]           amount;
  logic signed [SW-1:0]  amt_s, off_s, key_s, sum_add, sum_sub, t_s, val_s;
  logic signed [KEY_BITS-1:0] off_add, off_sub;
  logic                  key_oob, below_min, find_bad;
  logic [NB-1:0]         t_val, step_node;
  logic [COUNT_BITS-1:0] fix_sum, removed;
  logic [32:0]           dep_sum;
  logic [15:0]           dep_sat, entry_sat;
  logic                  out_free, zero_busy;

  ostc_mem #(.AW(NB), .DW(COUNT_BITS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_tready  = (state_r == ostc_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_free   = !out_valid_r || out_tready;

  assign amount    = in_tdata[11:0];
  assign amt_s     = SW'(amount);
  assign off_s     = SW'(offset_r);
  assign key_s     = amt_s - off_s;
  assign key_oob   = (key_s < -HALF_S) || (key_s > HALF_S - SW'(1));
  assign below_min = amount < min_level_r;
  assign find_bad  = (amount == 12'd0) || (33'(amount) > 33'(total_r));

  assign sum_add = off_s + amt_s;
  assign sum_sub = off_s - amt_s;
  assign off_add = (sum_add > HALF_S - SW'(1)) ? KEY_BITS'(HALF_S - SW'(1)) :
                   KEY_BITS'(sum_add);
  assign off_sub = (sum_sub < -HALF_S) ? KEY_BITS'(-HALF_S) : KEY_BITS'(sum_sub);

  assign t_s   = SW'(min_level_r) - off_s + HALF_S;
  assign t_val = (t_s < SW'(0)) ? '0 : (t_s > LEAVES_S) ? LEAVES : NB'(t_s);

  assign step_node = (mem_rdata >= k_r) ? {node_r[NB-2:0], 1'b1} : {node_r[NB-2:0], 1'b0};
  assign val_s     = SW'(step_node[KEY_BITS-1:0]) - HALF_S + off_s;

  assign fix_sum   = left_r + mem_rdata;
  assign zero_busy = j_r < zcnt_r;
  assign removed   = (state_r == ostc_pkg::S_FIX_WR) ? total_r - fix_sum : total_r;
  assign dep_sum   = 33'(departed_r) + 33'(removed);
  assign dep_sat   = (dep_sum > 33'(ostc_pkg::TOTAL_MAX)) ? ostc_pkg::TOTAL_MAX :
                     dep_sum[15:0];
  assign entry_sat = (33'(total_r) > 33'(ostc_pkg::TOTAL_MAX)) ? ostc_pkg::TOTAL_MAX :
                     16'(total_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ostc_pkg::S_CLEAR: begin
        if (clr_r == '1) state_nxt = ostc_pkg::S_IDLE;
      end
      ostc_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            ostc_pkg::REQ_INSERT: begin
              if (below_min || key_oob || total_r == COUNT_MAX) state_nxt = ostc_pkg::S_RESP;
              else state_nxt = ostc_pkg::S_INS_RD;
            end
            ostc_pkg::REQ_ADD:      state_nxt = ostc_pkg::S_RESP;
            ostc_pkg::REQ_SUBTRACT: state_nxt = ostc_pkg::S_SUB_T;
            ostc_pkg::REQ_FIND: begin
              state_nxt = find_bad ? ostc_pkg::S_RESP : ostc_pkg::S_FIND_RD;
            end
            default: state_nxt = ostc_pkg::S_RESP;
          endcase
        end
      end
      ostc_pkg::S_INS_RD: state_nxt = ostc_pkg::S_INS_WR;
      ostc_pkg::S_INS_WR: begin
        state_nxt = (node_r == ROOT) ? ostc_pkg::S_RESP : ostc_pkg::S_INS_RD;
      end
      ostc_pkg::S_FIND_RD: state_nxt = ostc_pkg::S_FIND_STEP;
      ostc_pkg::S_FIND_STEP: begin
        state_nxt = step_node[KEY_BITS] ? ostc_pkg::S_RESP : ostc_pkg::S_FIND_RD;
      end
      ostc_pkg::S_SUB_T: begin
        state_nxt = (total_r == '0 || t_val == '0) ? ostc_pkg::S_RESP : ostc_pkg::S_ZERO;
      end
      ostc_pkg::S_ZERO: begin
        if (!zero_busy && zbase_r == ROOT) begin
          state_nxt = t_r[KEY_BITS] ? ostc_pkg::S_RESP : ostc_pkg::S_FIX_RDL;
        end
      end
      ostc_pkg::S_FIX_RDL: state_nxt = ostc_pkg::S_FIX_RDR;
      ostc_pkg::S_FIX_RDR: state_nxt = ostc_pkg::S_FIX_WR;
      ostc_pkg::S_FIX_WR: begin
        state_nxt = (node_r == ROOT) ? ostc_pkg::S_RESP : ostc_pkg::S_FIX_RDL;
      end
      ostc_pkg::S_RESP: begin
        if (out_free) state_nxt = ostc_pkg::S_IDLE;
      end
      default: state_nxt = ostc_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    offset_nxt    = offset_r;
    departed_nxt  = departed_r;
    total_nxt     = total_r;
    k_nxt         = k_r;
    left_nxt      = left_r;
    node_nxt      = node_r;
    t_nxt         = t_r;
    zbase_nxt     = zbase_r;
    zcnt_nxt      = zcnt_r;
    j_nxt         = j_r;
    clr_nxt       = clr_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    mem_we        = 1'b0;
    mem_waddr     = node_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = node_r;
    case (state_r)
      ostc_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + NB'(1);
      end
      ostc_pkg::S_IDLE: begin
        status_nxt = ostc_pkg::ST_OK;
        found_nxt  = '0;
        if (in_acc) begin
          case (in_tuser)
            ostc_pkg::REQ_INSERT: begin
              if (below_min) status_nxt = ostc_pkg::ST_BELOW_MIN;
              else if (key_oob) status_nxt = ostc_pkg::ST_OUT_RANGE;
              node_nxt = LEAVES | NB'(KEY_BITS'(key_s + HALF_S));
            end
            ostc_pkg::REQ_ADD:      offset_nxt = off_add;
            ostc_pkg::REQ_SUBTRACT: offset_nxt = off_sub;
            ostc_pkg::REQ_FIND: begin
              if (find_bad) status_nxt = ostc_pkg::ST_NOT_FOUND;
              node_nxt = ROOT;
              k_nxt    = COUNT_BITS'(amount);
            end
            default: status_nxt = ostc_pkg::ST_OK;
          endcase
        end
      end
      ostc_pkg::S_INS_RD: mem_re = 1'b1;
      ostc_pkg::S_INS_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata + COUNT_BITS'(1);
        node_nxt  = node_r >> 1;
        if (node_r == ROOT) total_nxt = total_r + COUNT_BITS'(1);
      end
      ostc_pkg::S_FIND_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {node_r[NB-2:0], 1'b1};
      end
      ostc_pkg::S_FIND_STEP: begin
        node_nxt = step_node;
        if (mem_rdata < k_r) k_nxt = k_r - mem_rdata;
        if (val_s < SW'(0)) found_nxt = '0;
        else if (val_s > VMAX_S) found_nxt = ostc_pkg::VALUE_MAX;
        else found_nxt = 13'(val_s);
      end
      ostc_pkg::S_SUB_T: begin
        t_nxt     = t_val;
        zcnt_nxt  = t_val;
        zbase_nxt = LEAVES;
        j_nxt     = '0;
      end
      ostc_pkg::S_ZERO: begin
        mem_waddr = zbase_r + j_r;
        if (zero_busy) begin
          mem_we = 1'b1;
          j_nxt  = j_r + NB'(1);
        end else if (zbase_r == ROOT) begin
          node_nxt = NB'({1'b1, t_r[KEY_BITS-1:0]} >> 1);
          if (t_r[KEY_BITS]) begin
            departed_nxt = dep_sat;
            total_nxt    = '0;
          end
        end else begin
          zbase_nxt = zbase_r >> 1;
          zcnt_nxt  = zcnt_r >> 1;
          j_nxt     = '0;
        end
      end
      ostc_pkg::S_FIX_RDL: begin
        mem_re    = 1'b1;
        mem_raddr = {node_r[NB-2:0], 1'b0};
      end
      ostc_pkg::S_FIX_RDR: begin
        mem_re    = 1'b1;
        mem_raddr = {node_r[NB-2:0], 1'b1};
        left_nxt  = mem_rdata;
      end
      ostc_pkg::S_FIX_WR: begin
        mem_we    = 1'b1;
        mem_wdata = fix_sum;
        node_nxt  = node_r >> 1;
        if (node_r == ROOT) begin
          departed_nxt = dep_sat;
          total_nxt    = fix_sum;
        end
      end
      ostc_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = status_r;
          out_data_nxt  = {3'b000, departed_r, entry_sat, found_r};
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ostc_pkg::S_CLEAR;
      min_level_r <= '0;
      offset_r    <= '0;
      departed_r  <= '0;
      total_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) min_level_r <= cfg_wr_data;
      offset_r    <= offset_nxt;
      departed_r  <= departed_nxt;
      total_r     <= total_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    left_r     <= left_nxt;
    node_r     <= node_nxt;
    t_r        <= t_nxt;
    zbase_r    <= zbase_nxt;
    zcnt_r     <= zcnt_nxt;
    j_r        <= j_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ostc_pkg::S_CLEAR) |-> !in_tready)
    else $error("request taken during clearing pass");

  a_no_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != ostc_pkg::S_CLEAR) |-> (mem_waddr != '0))
    else $error("write to unused tree slot");

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ostc_pkg::S_IDLE))
    else $error("request finished without result");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ostc_pkg::S_RESP && out_free) |=> out_valid_r)
    else $error("result not presented");

endmodule

@@ sv/ostc_mem.sv @@
module ostc_mem #(
  parameter int AW = 14,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
